@@ rtl/cgtd_pkg.sv @@
// ----------------------------------------------------------------------------
// cgtd_pkg - shared types and constants
// Payload structs, register indexes and fixed constants of the colour gate,
// threshold and dilation block.
// ----------------------------------------------------------------------------
package cgtd_pkg;

  // widths fixed by the register map
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int GEOM_W     = 11;   // frame_width / frame_height field
  localparam int RAD_FLD_W  = 3;    // grow_radius field
  localparam int LUMA_LIM_W = 9;
  localparam int POS_W      = 10;   // out_col / out_row
  localparam int VROW_W     = 11;   // scan row, runs a few rows past the frame
  localparam int MAX_HEIGHT = 1024;

  // luma weights, 16-bit fraction
  localparam int LUMA_SUM_W = 24;
  localparam logic [15:0] LUMA_B = 16'd7471;
  localparam logic [15:0] LUMA_G = 16'd38470;
  localparam logic [15:0] LUMA_R = 16'd19595;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COLOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_LEVEL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LUMA_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GROW_RADIUS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd6;

  // item kinds and channel select
  localparam logic REQ_PIXEL   = 1'b0;
  localparam logic REQ_PAD     = 1'b1;
  localparam logic TARGET_RED  = 1'b0;
  localparam logic TARGET_BLUE = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } in_item_t;

  typedef struct packed {
    logic             pixel_on;
    logic [POS_W-1:0] out_col;
    logic [POS_W-1:0] out_row;
    logic             frame_last;
  } out_item_t;

  // per-item bookkeeping carried down the pipe
  typedef struct packed {
    logic             emit;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             last;
  } item_tag_t;

endpackage

@@ rtl/cgtd_gate.sv @@
// ----------------------------------------------------------------------------
// cgtd_gate - colour and luma threshold
// Marks a pixel on when the chosen channel is above its level and the
// fixed-point luma is below the limit. Padding items are always off.
// ----------------------------------------------------------------------------
module cgtd_gate
  import cgtd_pkg::*;
(
  input  in_item_t              pix,
  input  logic                  target_color,
  input  logic [7:0]            red_level,
  input  logic [7:0]            blue_level,
  input  logic [LUMA_LIM_W-1:0] luma_limit,
  output logic                  pix_on
);

  logic [LUMA_SUM_W-1:0] luma_sum;
  logic [7:0]            luma;
  logic                  chan_ok;
  logic                  luma_ok;

  assign luma_sum = LUMA_SUM_W'(LUMA_B * pix.blue_in)
                  + LUMA_SUM_W'(LUMA_G * pix.green_in)
                  + LUMA_SUM_W'(LUMA_R * pix.red_in);
  assign luma     = luma_sum[LUMA_SUM_W-1:16];
  assign luma_ok  = {1'b0, luma} < luma_limit;
  assign chan_ok  = (target_color == TARGET_BLUE) ? (pix.blue_in > blue_level)
                                                  : (pix.red_in > red_level);
  assign pix_on   = (pix.req_type == REQ_PIXEL) && chan_ok && luma_ok;

endmodule

@@ rtl/cgtd_scan.sv @@
// ----------------------------------------------------------------------------
// cgtd_scan - raster counters and first pipeline stage
// Tracks scan and emit positions, latches frame geometry at frame start and
// registers each accepted transaction with its row and column masks.
// ----------------------------------------------------------------------------
module cgtd_scan
  import cgtd_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          pix_on,
  input  logic [GEOM_W-1:0]             cfg_w,
  input  logic [GEOM_W-1:0]             cfg_h,
  input  logic [RAD_FLD_W-1:0]          cfg_r,
  input  logic                          s2_ready,
  output logic                          s1_valid,
  output item_tag_t                     s1_tag,
  output logic                          s1_bit,
  output logic [2*MAX_RADIUS:0]         s1_vmask,
  output logic [2*MAX_RADIUS:0]         s1_hmask,
  output logic                          rd_en,
  output logic [$clog2(MAX_WIDTH)-1:0]  rd_addr
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_RADIUS + 1);
  localparam int LW  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int TW  = $clog2(MAX_WIDTH + 2 * MAX_RADIUS + 1);
  localparam int NK  = 2 * MAX_RADIUS + 1;

  logic              start_r;
  logic [WW-1:0]     w_r;
  logic [GEOM_W-1:0] h_r;
  logic [RW-1:0]     r_r;
  logic [LW-1:0]     lag_r;
  logic [LW-1:0]     cnt_r;
  logic [CW-1:0]     vc_r;
  logic [VROW_W-1:0] vr_r;
  logic [CW-1:0]     ec_r;
  logic [POS_W-1:0]  er_r;

  logic              s1_v_r;
  item_tag_t         s1_tag_r;
  logic              s1_bit_r;
  logic [NK-1:0]     s1_vmask_r;
  logic [NK-1:0]     s1_hmask_r;

  logic [WW-1:0]     c_w, g_w;
  logic [GEOM_W-1:0] c_h, g_h;
  logic [RW-1:0]     c_r, g_r;
  logic [LW-1:0]     c_lag, g_lag;
  logic [CW-1:0]     g_wm1;
  logic [TW-1:0]     t_col;
  logic              accept, emit, last;
  logic [NK-1:0]     vmask, hmask;

  // clamp the geometry registers to what the block supports
  assign c_w = (cfg_w == '0) ? WW'(1)
             : ((32'(cfg_w) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_w));
  assign c_h = (cfg_h == '0) ? GEOM_W'(1)
             : ((32'(cfg_h) > MAX_HEIGHT) ? GEOM_W'(MAX_HEIGHT) : cfg_h);
  assign c_r = (32'(cfg_r) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(cfg_r);
  assign c_lag = LW'(c_r) * LW'(c_w) + LW'(c_r);

  // first item of a frame uses fresh geometry
  assign g_w   = start_r ? c_w   : w_r;
  assign g_h   = start_r ? c_h   : h_r;
  assign g_r   = start_r ? c_r   : r_r;
  assign g_lag = start_r ? c_lag : lag_r;
  assign g_wm1 = CW'(g_w - WW'(1));

  assign in_ready = !s1_v_r || s2_ready;
  assign accept   = in_valid && in_ready;
  assign emit     = (cnt_r == g_lag);
  assign last     = emit && (er_r == POS_W'(g_h - GEOM_W'(1))) && (ec_r == g_wm1);
  assign t_col    = TW'(ec_r) + TW'(g_r);

  // vertical mask: rows inside the window and not above the frame top;
  // horizontal mask: columns of the emit row inside the frame
  always_comb begin
    for (int k = 0; k < NK; k++) begin
      vmask[k] = ((RW+1)'(k) <= {g_r, 1'b0}) && (VROW_W'(k) <= vr_r);
      hmask[k] = ((RW+1)'(k) <= {g_r, 1'b0}) && (TW'(k) <= t_col)
              && (t_col <= TW'(g_wm1) + TW'(k));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b1;
      w_r     <= '0;
      h_r     <= '0;
      r_r     <= '0;
      lag_r   <= '0;
      cnt_r   <= '0;
      vc_r    <= '0;
      vr_r    <= '0;
      ec_r    <= '0;
      er_r    <= '0;
    end else if (accept) begin
      if (start_r) begin
        w_r   <= c_w;
        h_r   <= c_h;
        r_r   <= c_r;
        lag_r <= c_lag;
      end
      start_r <= last;
      if (last) begin
        cnt_r <= '0;
        vc_r  <= '0;
        vr_r  <= '0;
        ec_r  <= '0;
        er_r  <= '0;
      end else begin
        if (!emit) begin
          cnt_r <= cnt_r + LW'(1);
        end
        if (vc_r == g_wm1) begin
          vc_r <= '0;
          vr_r <= vr_r + VROW_W'(1);
        end else begin
          vc_r <= vc_r + CW'(1);
        end
        if (emit) begin
          if (ec_r == g_wm1) begin
            ec_r <= '0;
            er_r <= er_r + POS_W'(1);
          end else begin
            ec_r <= ec_r + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s2_ready) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tag_r.emit <= emit;
      s1_tag_r.col  <= POS_W'(ec_r);
      s1_tag_r.row  <= er_r;
      s1_tag_r.last <= last;
      s1_bit_r      <= pix_on && (vr_r < g_h);
      s1_vmask_r    <= vmask;
      s1_hmask_r    <= hmask;
    end
  end

  assign s1_valid = s1_v_r;
  assign s1_tag   = s1_tag_r;
  assign s1_bit   = s1_bit_r;
  assign s1_vmask = s1_vmask_r;
  assign s1_hmask = s1_hmask_r;
  assign rd_en    = accept;
  assign rd_addr  = vc_r;

endmodule

@@ rtl/cgtd_column.sv @@
// ----------------------------------------------------------------------------
// cgtd_column - line store and vertical dilation
// Keeps the last rows of every column as a bit vector, shifts in the new
// pixel and ORs the rows that fall inside the window.
// ----------------------------------------------------------------------------
module cgtd_column #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 4
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
  input  logic                          adv,
  input  logic                          s1_bit,
  input  logic [2*MAX_RADIUS:0]         s1_vmask,
  output logic                          vbit
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int HB = 2 * MAX_RADIUS;

  logic [HB-1:0] mem_r [MAX_WIDTH];
  logic [HB-1:0] rd_r;
  logic [CW-1:0] addr_r;
  logic [HB:0]   col_vec;
  logic [HB-1:0] wr_word;

  assign col_vec = {rd_r, s1_bit};
  assign wr_word = col_vec[HB-1:0];
  assign vbit    = |(col_vec & s1_vmask);

  always_ff @(posedge clk) begin
    if (adv) begin
      mem_r[addr_r] <= wr_word;
    end
  end

  // forward the word being written when the next transaction hits it
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (adv && (addr_r == rd_addr)) begin
        rd_r <= wr_word;
      end else begin
        rd_r <= mem_r[rd_addr];
      end
      addr_r <= rd_addr;
    end
  end

endmodule

@@ rtl/cgtd_window.sv @@
// ----------------------------------------------------------------------------
// cgtd_window - horizontal dilation and result register
// Shifts column results into a short line, ORs the columns inside the
// clipped window and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module cgtd_window
  import cgtd_pkg::*;
#(
  parameter int MAX_RADIUS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  s1_valid,
  input  item_tag_t             s1_tag,
  input  logic                  vbit,
  input  logic [2*MAX_RADIUS:0] s1_hmask,
  output logic                  s2_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  localparam int NK = 2 * MAX_RADIUS + 1;

  logic [NK-1:0] hreg_r;
  logic          s2_v_r;
  item_tag_t     s2_tag_r;
  logic [NK-1:0] s2_hmask_r;
  logic          out_v_r;
  out_item_t     out_r;
  logic          s2_go;
  logic          load;

  assign s2_go    = s2_v_r && (!s2_tag_r.emit || !out_v_r || out_ready);
  assign s2_ready = !s2_v_r || s2_go;
  assign load     = s1_valid && s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      hreg_r <= '0;
    end else if (load) begin
      s2_v_r <= 1'b1;
      hreg_r <= {hreg_r[NK-2:0], vbit};
    end else if (s2_go) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2_tag_r   <= s1_tag;
      s2_hmask_r <= s1_hmask;
    end
  end

  // fill-in transactions leave no result: drop them here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s2_go && s2_tag_r.emit) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_tag_r.emit) begin
      out_r.pixel_on   <= |(hreg_r & s2_hmask_r);
      out_r.out_col    <= s2_tag_r.col;
      out_r.out_row    <= s2_tag_r.row;
      out_r.frame_last <= s2_tag_r.last;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

@@ rtl/color_gate_threshold_dilate.sv @@
// ----------------------------------------------------------------------------
// color_gate_threshold_dilate - colour gate, threshold and square dilation
// BGR pixels arrive in raster order on in_valid/in_ready/in_data; each is
// marked on when the chosen channel is above its level and the luma is
// below luma_limit, and the binary image is dilated by a (2r+1) square
// clipped at the frame borders.
// One transaction is taken every cycle while in_ready is high; the pipe is
// three registers deep: scan, window and output, in that order. A pixel is
// released r rows plus r pixels after it entered, so a frame takes
// W*H + r*W + r transactions; padding items flush the tail and frame_last
// flags the final pixel. Frame geometry is taken from the registers at the
// first transaction of each frame. The user must write the registers on
// cfg_wr_en only while idle; the block itself does not enforce it.
// When out_ready is low the result is held and the pipe keeps taking
// transactions until all three stages are full, then in_ready drops.
// Reset clears the counters, the pipe and the registers to their defaults.
// The line store needs no clearing pass: a column word is only used for
// rows already written in the current frame.
// ----------------------------------------------------------------------------
module color_gate_threshold_dilate
  import cgtd_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic                  target_r;
  logic [7:0]            red_level_r;
  logic [7:0]            blue_level_r;
  logic [LUMA_LIM_W-1:0] luma_limit_r;
  logic [RAD_FLD_W-1:0]  radius_r;
  logic [GEOM_W-1:0]     width_r;
  logic [GEOM_W-1:0]     height_r;

  logic                  pix_on;
  logic                  s1_valid;
  item_tag_t             s1_tag;
  logic                  s1_bit;
  logic [2*MAX_RADIUS:0] s1_vmask;
  logic [2*MAX_RADIUS:0] s1_hmask;
  logic                  rd_en;
  logic [CW-1:0]         rd_addr;
  logic                  s2_ready;
  logic                  vbit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r     <= TARGET_RED;
      red_level_r  <= 8'd128;
      blue_level_r <= 8'd128;
      luma_limit_r <= 9'd128;
      radius_r     <= 3'd1;
      width_r      <= 11'd640;
      height_r     <= 11'd480;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TARGET_COLOR: target_r     <= cfg_data[0];
        CFG_RED_LEVEL:    red_level_r  <= cfg_data[7:0];
        CFG_BLUE_LEVEL:   blue_level_r <= cfg_data[7:0];
        CFG_LUMA_LIMIT:   luma_limit_r <= cfg_data[LUMA_LIM_W-1:0];
        CFG_GROW_RADIUS:  radius_r     <= cfg_data[RAD_FLD_W-1:0];
        CFG_FRAME_WIDTH:  width_r      <= cfg_data;
        CFG_FRAME_HEIGHT: height_r     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  cgtd_gate u_gate (
    .pix          (in_data),
    .target_color (target_r),
    .red_level    (red_level_r),
    .blue_level   (blue_level_r),
    .luma_limit   (luma_limit_r),
    .pix_on       (pix_on)
  );

  cgtd_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .pix_on   (pix_on),
    .cfg_w    (width_r),
    .cfg_h    (height_r),
    .cfg_r    (radius_r),
    .s2_ready (s2_ready),
    .s1_valid (s1_valid),
    .s1_tag   (s1_tag),
    .s1_bit   (s1_bit),
    .s1_vmask (s1_vmask),
    .s1_hmask (s1_hmask),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr)
  );

  cgtd_column #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_column (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .adv      (s1_valid && s2_ready),
    .s1_bit   (s1_bit),
    .s1_vmask (s1_vmask),
    .vbit     (vbit)
  );

  cgtd_window #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_tag    (s1_tag),
    .vbit      (vbit),
    .s1_hmask  (s1_hmask),
    .s2_ready  (s2_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
